FILE: hw/rtl/gmcp_pkg.sv
// Shared types and constants of the grid minimum-cost path block.
package gmcp_pkg;

   // Field widths.
   localparam int CELL_W = 16;
   localparam int COST_W = 32;
   localparam int CNT_W  = 7;
   localparam int IDX_W  = 8;

   // Largest number of grid rows in use.
   localparam int MAX_ROWS = 64;

   // Register indexes of the configuration port.
   localparam logic [IDX_W-1:0] REG_ROW_COUNT = 8'd0;
   localparam logic [IDX_W-1:0] REG_COL_COUNT = 8'd1;

   // Saturation value of a path cost.
   localparam logic [COST_W-1:0] COST_SAT = '1;

   // One result on its way to the response channel.
   typedef struct packed {
      logic [COST_W-1:0] path_cost;
      logic              is_final;
   } rsp_type;

endpackage

FILE: hw/rtl/gmcp_cell.sv
// One entry of the row store, taking its neighbor's value or the new result on every shift.
module gmcp_cell
   import gmcp_pkg::*;
(
   input  logic              clock,
   input  logic              shift,
   input  logic              load,
   input  logic [COST_W-1:0] load_value,
   input  logic [COST_W-1:0] next_value,
   output logic [COST_W-1:0] value
);

   logic [COST_W-1:0] value_ff;
   logic [COST_W-1:0] value_in;

   // The head cell takes the new result, every other cell its upper neighbor.
   always_comb begin
      value_in = value_ff;
      if (shift) begin
         value_in = load ? load_value : next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

FILE: hw/rtl/gmcp_row_chain.sv
// Row store built as a chain of cells; a result leaves at cell 0 one row later.
module gmcp_row_chain
   import gmcp_pkg::*;
#(
   parameter int DEPTH = 64
)
(
   input  logic              clock,
   input  logic              shift,
   input  logic [CNT_W-1:0]  head,
   input  logic [COST_W-1:0] load_value,
   output logic [COST_W-1:0] below_value
);

   logic [COST_W-1:0] cell_value [DEPTH];

   // Cell k hands its value to cell k-1; the topmost cell refills from the new result.
   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic [COST_W-1:0] upper_value;

      if (k == DEPTH - 1) begin : g_top
         assign upper_value = load_value;
      end else begin : g_mid
         assign upper_value = cell_value[k+1];
      end

      gmcp_cell u_cell (
         .clock      (clock),
         .shift      (shift),
         .load       (head == CNT_W'(k)),
         .load_value (load_value),
         .next_value (upper_value),
         .value      (cell_value[k])
      );
   end

   assign below_value = cell_value[0];

endmodule

FILE: hw/rtl/gmcp_rsp_queue.sv
// Two-entry response queue that decouples the datapath from response stalls.
module gmcp_rsp_queue
   import gmcp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic [1:0] count_ff;
   logic [1:0] count_in;
   rsp_type    slot0_ff;
   rsp_type    slot0_in;
   rsp_type    slot1_ff;
   rsp_type    slot1_in;
   logic       pop;

   assign pop = (count_ff != 2'd0) && !rsp_stall;

   // A push never meets a full queue, so the head moves up before a new entry lands.
   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      case ({push, pop})
         2'b10: begin
            count_in = count_ff + 2'd1;
            if (count_ff == 2'd0) begin
               slot0_in = push_data;
            end else begin
               slot1_in = push_data;
            end
         end
         2'b01: begin
            count_in = count_ff - 2'd1;
            slot0_in = slot1_ff;
         end
         2'b11: begin
            slot0_in = push_data;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign full      = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = slot0_ff;

endmodule

FILE: hw/rtl/grid_min_cost_path.sv
// Top level of the grid minimum-cost path block.
//
//   Channel  Direction  Handshake              Payload
//   req_     in         req_valid / req_stall  req_cell_cost[15:0]
//   rsp_     out        rsp_valid / rsp_stall  rsp_path_cost[31:0], rsp_is_final
//   csr_     in         csr_valid / csr_ready  csr_index[7:0], csr_data[6:0]
//
// One request is taken per cycle unless the response queue is full; its result
// enters the response queue at the same edge. The rate is set by the loop from a
// result to the right-hand value of the next cell: one add and a three-way min.
// The row below is held in a chain of COL_CAP cells that shifts once per request.
// Reset is synchronous; it selects a 1 x 1 grid. Requests stall only while both
// response queue entries wait. A write to a count register restarts the grid.
module grid_min_cost_path
   import gmcp_pkg::*;
#(
   parameter int MAX_COLS = 64
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CELL_W-1:0] req_cell_cost,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [COST_W-1:0] rsp_path_cost,
   output logic              rsp_is_final,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [CNT_W-1:0]  csr_data
);

   // Largest usable counts: the register width bounds them as well.
   localparam int COL_CAP = (MAX_COLS < 127) ? MAX_COLS : 127;
   localparam int ROW_CAP = (MAX_ROWS < 127) ? MAX_ROWS : 127;
   localparam logic [CNT_W-1:0] COL_CAP_V = CNT_W'(COL_CAP);
   localparam logic [CNT_W-1:0] ROW_CAP_V = CNT_W'(ROW_CAP);

   logic [CNT_W-1:0]  rows_last_ff, rows_last_in;
   logic [CNT_W-1:0]  cols_last_ff, cols_last_in;
   logic [CNT_W-1:0]  row_pos_ff, row_pos_in;
   logic [CNT_W-1:0]  col_pos_ff, col_pos_in;
   logic [COST_W-1:0] right_ff, right_in;
   logic [COST_W-1:0] lower_right_ff, lower_right_in;

   logic              req_take;
   logic              csr_take;
   logic              queue_full;
   logic [CNT_W-1:0]  write_count;
   logic [CNT_W-1:0]  write_last;
   logic              last_row;
   logic              last_col;
   logic [COST_W-1:0] below;
   logic [COST_W-1:0] min_below;
   logic [COST_W-1:0] addend;
   logic [COST_W:0]   sum;
   logic [COST_W-1:0] cost;
   rsp_type           push_data;
   rsp_type           rsp_data;

   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid && csr_ready;
   assign req_stall = queue_full;
   assign req_take  = req_valid && !req_stall;

   // A count of zero acts as one, a count above the cap as the cap; store count minus one.
   always_comb begin
      write_count = (csr_data == '0) ? CNT_W'(1) : csr_data;
      write_last  = '0;
      case (csr_index)
         REG_ROW_COUNT: begin
            write_last = ((write_count > ROW_CAP_V) ? ROW_CAP_V : write_count) - CNT_W'(1);
         end
         REG_COL_COUNT: begin
            write_last = ((write_count > COL_CAP_V) ? COL_CAP_V : write_count) - CNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   // Cost of the current cell from its right, lower and lower-right neighbors.
   assign last_row  = (row_pos_ff == rows_last_ff);
   assign last_col  = (col_pos_ff == cols_last_ff);
   assign min_below = (below < lower_right_ff) ? below : lower_right_ff;

   always_comb begin
      if (last_row && last_col) begin
         addend = '0;
      end else if (last_row) begin
         addend = right_ff;
      end else if (last_col) begin
         addend = below;
      end else begin
         addend = (right_ff < min_below) ? right_ff : min_below;
      end
   end

   assign sum  = {{(COST_W + 1 - CELL_W){1'b0}}, req_cell_cost} + {1'b0, addend};
   assign cost = sum[COST_W] ? COST_SAT : sum[COST_W-1:0];

   // Position walk, neighbor values and register writes.
   always_comb begin
      rows_last_in   = rows_last_ff;
      cols_last_in   = cols_last_ff;
      row_pos_in     = row_pos_ff;
      col_pos_in     = col_pos_ff;
      right_in       = right_ff;
      lower_right_in = lower_right_ff;
      if (csr_take && (csr_index == REG_ROW_COUNT || csr_index == REG_COL_COUNT)) begin
         if (csr_index == REG_ROW_COUNT) begin
            rows_last_in = write_last;
         end else begin
            cols_last_in = write_last;
         end
         row_pos_in     = (csr_index == REG_ROW_COUNT) ? write_last : rows_last_ff;
         col_pos_in     = (csr_index == REG_COL_COUNT) ? write_last : cols_last_ff;
         right_in       = '0;
         lower_right_in = '0;
      end else if (req_take) begin
         if (col_pos_ff == '0) begin
            col_pos_in     = cols_last_ff;
            row_pos_in     = (row_pos_ff == '0) ? rows_last_ff : row_pos_ff - CNT_W'(1);
            right_in       = '0;
            lower_right_in = '0;
         end else begin
            col_pos_in     = col_pos_ff - CNT_W'(1);
            right_in       = cost;
            lower_right_in = below;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_last_ff   <= '0;
         cols_last_ff   <= '0;
         row_pos_ff     <= '0;
         col_pos_ff     <= '0;
         right_ff       <= '0;
         lower_right_ff <= '0;
      end else begin
         rows_last_ff   <= rows_last_in;
         cols_last_ff   <= cols_last_in;
         row_pos_ff     <= row_pos_in;
         col_pos_ff     <= col_pos_in;
         right_ff       <= right_in;
         lower_right_ff <= lower_right_in;
      end
   end

   // Row store: the result enters at the cell for the last column.
   gmcp_row_chain #(
      .DEPTH (COL_CAP)
   ) u_row_chain (
      .clock       (clock),
      .shift       (req_take),
      .head        (cols_last_ff),
      .load_value  (cost),
      .below_value (below)
   );

   // Results wait in the response queue.
   assign push_data.path_cost = cost;
   assign push_data.is_final  = (row_pos_ff == '0) && (col_pos_ff == '0);

   gmcp_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_take),
      .push_data (push_data),
      .full      (queue_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_path_cost = rsp_data.path_cost;
   assign rsp_is_final  = rsp_data.is_final;

endmodule

FILE: verif/grid_min_cost_path_test.sv
// Self-checking testbench of the grid minimum-cost path block.
`timescale 1ns / 100ps

module grid_min_cost_path_test
   import gmcp_pkg::*;
();

   localparam int GRID_MAX_COLS = 64;
   localparam int COL_IDX_W     = $clog2(GRID_MAX_COLS);
   localparam int RANDOM_ITEMS  = 800;
   localparam int IDLE_LIMIT    = 2000;
   localparam int DRAIN_CYCLES  = 20;

   // Register indexes outside the register list; writes to them are ignored.
   localparam logic [IDX_W-1:0] REG_UNUSED  = 8'd2;
   localparam logic [IDX_W-1:0] NO_SUCH_REG = 8'hFF;

   // Scoreboard: tracks the grid position and the row below, and holds the
   // path costs that are still owed by the block.
   class path_cost_board;
      rsp_type           expected_results[$];
      logic [COST_W-1:0] lower_row [GRID_MAX_COLS];
      logic [COST_W-1:0] right_cost;
      logic [COST_W-1:0] lower_right_cost;
      logic [CNT_W-1:0]  row_count_reg;
      logic [CNT_W-1:0]  col_count_reg;
      logic [CNT_W-1:0]  row_pos;
      logic [CNT_W-1:0]  col_pos;
      int                mismatches;

      function new();
         row_count_reg = 1;
         col_count_reg = 1;
         mismatches = 0;
         foreach (lower_row[i]) lower_row[i] = '0;
         restart();
      endfunction

      // A count of zero acts as one; a count above the limit acts as the limit.
      function int grid_rows();
         if (row_count_reg == 0) return 1;
         if (row_count_reg > MAX_ROWS) return MAX_ROWS;
         return row_count_reg;
      endfunction

      function int grid_cols();
         if (col_count_reg == 0) return 1;
         if (col_count_reg > GRID_MAX_COLS) return GRID_MAX_COLS;
         return col_count_reg;
      endfunction

      // Go back to the bottom-right corner of the grid.
      function void restart();
         row_pos = CNT_W'(grid_rows() - 1);
         col_pos = CNT_W'(grid_cols() - 1);
         right_cost = '0;
         lower_right_cost = '0;
      endfunction

      function logic [COST_W-1:0] sat_sum(logic [COST_W-1:0] a, logic [COST_W-1:0] b);
         logic [COST_W:0] total;
         total = {1'b0, a} + {1'b0, b};
         return total[COST_W] ? COST_SAT : total[COST_W-1:0];
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      // Every write to a known register restarts the grid.
      function void note_write(logic [IDX_W-1:0] idx, logic [CNT_W-1:0] value);
         case (idx)
            REG_ROW_COUNT: begin
               row_count_reg = value;
               restart();
            end
            REG_COL_COUNT: begin
               col_count_reg = value;
               restart();
            end
            default: ;
         endcase
      endfunction

      // Work out the path cost of one accepted cell and advance the position.
      function void note_cell(logic [CELL_W-1:0] cell_cost);
         int                rows;
         int                cols;
         logic [COST_W-1:0] below;
         logic [COST_W-1:0] best;
         logic [COST_W-1:0] cost;
         logic              last_row;
         logic              last_col;
         rsp_type           item;
         rows = grid_rows();
         cols = grid_cols();
         below = lower_row[col_pos[COL_IDX_W-1:0]];
         last_row = (row_pos == rows - 1);
         last_col = (col_pos == cols - 1);

         if (last_row && last_col) begin
            cost = COST_W'(cell_cost);
         end else if (last_row) begin
            cost = sat_sum(COST_W'(cell_cost), right_cost);
         end else if (last_col) begin
            cost = sat_sum(COST_W'(cell_cost), below);
         end else begin
            best = (below < lower_right_cost) ? below : lower_right_cost;
            if (right_cost < best) best = right_cost;
            cost = sat_sum(COST_W'(cell_cost), best);
         end

         lower_right_cost = below;
         lower_row[col_pos[COL_IDX_W-1:0]] = cost;
         right_cost = cost;
         item.path_cost = cost;
         item.is_final = (row_pos == 0) && (col_pos == 0);

         // Leaving column 0 moves up a row, or wraps to a new grid at the top.
         if (col_pos == 0) begin
            col_pos = CNT_W'(cols - 1);
            row_pos = (row_pos == 0) ? CNT_W'(rows - 1) : row_pos - 1'b1;
            right_cost = '0;
            lower_right_cost = '0;
         end else begin
            col_pos = col_pos - 1'b1;
         end
         expected_results.push_back(item);
      endfunction

      // Compare one result with the oldest expected one.
      function void check_result(logic [COST_W-1:0] cost, logic fin);
         rsp_type want;
         if (expected_results.size() == 0) begin
            $error("result with no request waiting: path_cost %0d is_final %0d", cost, fin);
            mismatches++;
            return;
         end
         want = expected_results.pop_front();
         if (cost !== want.path_cost) begin
            $error("path_cost expected %0d actual %0d", want.path_cost, cost);
            mismatches++;
         end
         if (fin !== want.is_final) begin
            $error("is_final expected %0d actual %0d", want.is_final, fin);
            mismatches++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [CELL_W-1:0] req_cell_cost = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [COST_W-1:0] rsp_path_cost;
   logic              rsp_is_final;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [IDX_W-1:0]  csr_index = '0;
   logic [CNT_W-1:0]  csr_data = '0;

   path_cost_board    cost_board;
   logic [CELL_W-1:0] planned_cells[$];
   bit                sender_gaps = 1'b1;

   grid_min_cost_path #(
      .MAX_COLS(GRID_MAX_COLS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cell_cost(req_cell_cost),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_path_cost(rsp_path_cost),
      .rsp_is_final(rsp_is_final),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Write one register once every owed result has arrived.
   task automatic csr_write(input logic [IDX_W-1:0] idx, input logic [CNT_W-1:0] value);
      while (cost_board.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      cost_board.note_write(idx, value);
   endtask

   // Queue random cell costs, weighted toward the extremes.
   task automatic plan_random_cells(input int count);
      repeat (count) begin
         case ($urandom_range(0, 19))
            0, 1, 2: planned_cells.push_back('0);
            3, 4, 5: planned_cells.push_back('1);
            6, 7:    planned_cells.push_back(CELL_W'($urandom_range(0, 15)));
            default: planned_cells.push_back(CELL_W'($urandom));
         endcase
      end
   endtask

   // Send every queued cell as a request. At index drain_at the sender
   // holds off until the block has returned every owed result.
   task automatic send_cells(input int drain_at);
      int               gap;
      int               pick;
      int               idx;
      logic [CELL_W-1:0] cell_cost;
      idx = 0;
      while (planned_cells.size() != 0) begin
         cell_cost = planned_cells.pop_front();
         gap = 0;
         if (sender_gaps) begin
            pick = $urandom_range(0, 19);
            if (pick == 19) gap = $urandom_range(10, 40);
            else if (pick >= 14) gap = $urandom_range(1, 3);
         end
         if (idx == drain_at && gap == 0) gap = 1;
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
            if (idx == drain_at) begin
               while (cost_board.pending() != 0) @(posedge clock);
            end
         end
         req_valid <= 1'b1;
         req_cell_cost <= cell_cost;
         do @(posedge clock); while (req_stall !== 1'b0);
         cost_board.note_cell(cell_cost);
         idx++;
      end
      req_valid <= 1'b0;
   endtask

   // Receiver: short stalls with the odd long one, and calm stretches.
   initial begin : rsp_stall_pattern
      int run_len;
      int stall_len;
      @(posedge clock);
      forever begin
         run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 12);
         rsp_stall <= 1'b0;
         repeat (run_len) @(posedge clock);
         stall_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 3);
         rsp_stall <= 1'b1;
         repeat (stall_len) @(posedge clock);
      end
   end

   // Check each result as it leaves the block.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         cost_board.check_result(rsp_path_cost, rsp_is_final);
      end
   end

   // Watchdog: end the run when nothing has moved for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0) ||
             (csr_valid === 1'b1 && csr_ready === 1'b1)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("FAIL grid_min_cost_path");
      $finish;
   end

   // Main sequence: directed grids, extreme sizes, then random phases.
   initial begin : stimulus
      int               random_sent;
      int               grid_cells;
      int               cells;
      int               drain_at;
      bit               first_phase;
      logic [CNT_W-1:0] rows_raw;
      logic [CNT_W-1:0] cols_raw;
      cost_board = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The reset grid is a single cell, so each request is final by itself.
      planned_cells = '{16'h0000, 16'hFFFF};
      send_cells(-1);

      // A 2 x 3 grid, restarted after its bottom row, then run in full.
      csr_write(REG_ROW_COUNT, 7'd2);
      csr_write(REG_COL_COUNT, 7'd3);
      planned_cells = '{16'hFFFF, 16'h0000, 16'h0001};
      send_cells(-1);
      csr_write(REG_COL_COUNT, 7'd3);
      planned_cells = '{16'hFFFF, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
      send_cells(-1);

      // A single column uses only the cell below.
      csr_write(REG_ROW_COUNT, 7'd3);
      csr_write(REG_COL_COUNT, 7'd1);
      planned_cells = '{16'h0005, 16'hFFFF, 16'h0000};
      send_cells(-1);

      // A single row; an ignored write in the middle must not restart it.
      csr_write(REG_ROW_COUNT, 7'd1);
      csr_write(REG_COL_COUNT, 7'd4);
      planned_cells = '{16'h0001, 16'h0002};
      send_cells(-1);
      csr_write(REG_UNUSED, 7'h55);
      planned_cells = '{16'hFFFF, 16'h0000};
      send_cells(-1);

      // Counts of zero act as one.
      csr_write(REG_ROW_COUNT, 7'd0);
      csr_write(REG_COL_COUNT, 7'd0);
      csr_write(NO_SUCH_REG, 7'h7F);
      planned_cells = '{16'h1234, 16'h4321};
      send_cells(-1);

      // Largest sizes: a partial full-size grid, a tall grid and a wide grid.
      csr_write(REG_ROW_COUNT, 7'd127);
      csr_write(REG_COL_COUNT, 7'd127);
      plan_random_cells(200);
      send_cells(-1);
      csr_write(REG_ROW_COUNT, 7'd64);
      csr_write(REG_COL_COUNT, 7'd2);
      plan_random_cells(128);
      send_cells(-1);
      csr_write(REG_ROW_COUNT, 7'd1);
      csr_write(REG_COL_COUNT, 7'd64);
      plan_random_cells(64);
      send_cells(-1);

      // Random phases of whole and partial grids of mostly small sizes.
      random_sent = 0;
      first_phase = 1'b1;
      while (random_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: begin
               rows_raw = CNT_W'($urandom_range(64, 127));
               cols_raw = CNT_W'($urandom_range(0, 2));
            end
            1: begin
               rows_raw = CNT_W'($urandom_range(0, 2));
               cols_raw = CNT_W'($urandom_range(64, 127));
            end
            default: begin
               rows_raw = CNT_W'($urandom_range(0, 6));
               cols_raw = CNT_W'($urandom_range(0, 8));
            end
         endcase
         case ($urandom_range(0, 7))
            0: csr_write(IDX_W'($urandom_range(2, 255)), CNT_W'($urandom));
            1: csr_write(REG_ROW_COUNT, rows_raw);
            2: csr_write(REG_COL_COUNT, cols_raw);
            3: begin
               csr_write(REG_COL_COUNT, cols_raw);
               csr_write(REG_ROW_COUNT, rows_raw);
            end
            default: begin
               csr_write(REG_ROW_COUNT, rows_raw);
               csr_write(REG_COL_COUNT, cols_raw);
               if ($urandom_range(0, 4) == 0) begin
                  csr_write(IDX_W'($urandom_range(2, 255)), CNT_W'($urandom));
               end
            end
         endcase

         grid_cells = cost_board.grid_rows() * cost_board.grid_cols();
         cells = grid_cells * $urandom_range(1, 3);
         if ($urandom_range(0, 2) == 0) cells += $urandom_range(1, grid_cells);
         drain_at = (first_phase || $urandom_range(0, 7) == 0) ?
                    $urandom_range(0, cells - 1) : -1;
         sender_gaps = ($urandom_range(0, 3) != 0);
         first_phase = 1'b0;
         plan_random_cells(cells);
         send_cells(drain_at);
         random_sent += cells;
      end

      // Wait for every owed result, then a little longer for strays.
      while (cost_board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (cost_board.mismatches == 0 && cost_board.pending() == 0) begin
         $display("PASS grid_min_cost_path");
      end else begin
         $display("FAIL grid_min_cost_path");
      end
      $finish;
   end

endmodule

FILE: grid_min_cost_path.f
hw/rtl/gmcp_pkg.sv
hw/rtl/gmcp_cell.sv
hw/rtl/gmcp_row_chain.sv
hw/rtl/gmcp_rsp_queue.sv
hw/rtl/grid_min_cost_path.sv
verif/grid_min_cost_path_test.sv
